/* hdl/htlm_pkg.sv */
// shared types, constants and helper functions for the tree lock manager
// no dependencies; imported by every module of the block but htlm_ram
package htlm_pkg;

  localparam int MAX_NODES  = 64;
  localparam int MAX_BRANCH = 8;
  localparam int NODE_W     = 6;
  localparam int USER_W     = 16;
  localparam int CNT_W      = 7;
  localparam int BR_W       = 4;
  localparam int LVL_W      = 10;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [1:0] OP_LOCK    = 2'd0;
  localparam logic [1:0] OP_UNLOCK  = 2'd1;
  localparam logic [1:0] OP_UPGRADE = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  localparam logic REG_NODE_COUNT = 1'b0;
  localparam logic REG_BRANCH     = 1'b1;

  localparam logic [CNT_W-1:0] NODE_COUNT_RST = CNT_W'(64);
  localparam logic [BR_W-1:0]  BRANCH_RST     = BR_W'(2);

  typedef struct packed {
    logic [CNT_W-1:0] n;  // effective node count
    logic [BR_W-1:0]  m;  // effective branching factor
  } cfg_t;

  typedef struct packed {
    logic load;
    logic anc_step;
    logic desc_begin;
    logic desc_step;
    logic commit_lock;
    logic commit_unlock;
    logic set_res;
    logic res_val;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic       idx_ok;
    logic [1:0] op;
    logic       idx_locked;
    logic       cur_root;
    logic       par_locked;
    logic       first_out;
    logic       level_end;
    logic       next_out;
    logic       seen;
    logic       clean_now;
    logic       owner_match;
    logic       out_free;
  } sts_t;

  typedef struct packed {
    logic [NODE_W-1:0] lo;
    logic [NODE_W-1:0] hi;
    logic              out;  // level starts at or beyond the node count
  } lvl_t;

  // parent of a non-root node: (cur-1)/m by reciprocal multiply, m in 1..8
  function automatic logic [NODE_W-1:0] parent_of(logic [NODE_W-1:0] cur,
                                                  logic [BR_W-1:0] m);
    logic [NODE_W-1:0] v;
    logic [15:0]       p;
    logic [NODE_W-1:0] q;
    v = cur - NODE_W'(1);
    p = 16'd0;
    case (m)
      BR_W'(1): q = v;
      BR_W'(2): q = v >> 1;
      BR_W'(3): begin
        p = 16'(v) * 16'd43;
        q = p[12:7];
      end
      BR_W'(4): q = v >> 2;
      BR_W'(5): begin
        p = 16'(v) * 16'd205;
        q = p[15:10];
      end
      BR_W'(6): begin
        p = 16'(v) * 16'd43;
        q = p[13:8];
      end
      BR_W'(7): begin
        p = 16'(v) * 16'd147;
        q = p[15:10];
      end
      default: q = v >> 3;
    endcase
    return q;
  endfunction

  // children range of the level below [lo, hi], clipped to the node count
  function automatic lvl_t next_level(logic [NODE_W-1:0] lo, logic [NODE_W-1:0] hi,
                                      logic [BR_W-1:0] m, logic [CNT_W-1:0] n);
    logic [LVL_W-1:0] lo_n;
    logic [LVL_W-1:0] hi_n;
    logic [LVL_W-1:0] last;
    lvl_t             r;
    lo_n  = LVL_W'(lo) * LVL_W'(m) + LVL_W'(1);
    hi_n  = LVL_W'(hi) * LVL_W'(m) + LVL_W'(m);
    last  = LVL_W'(n) - LVL_W'(1);
    r.out = lo_n >= LVL_W'(n);
    r.lo  = lo_n[NODE_W-1:0];
    r.hi  = (hi_n > last) ? last[NODE_W-1:0] : hi_n[NODE_W-1:0];
    return r;
  endfunction

endpackage

/* hdl/htlm_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module htlm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/htlm_regs.sv */
// apb configuration registers: node count and branching factor
// depends on htlm_pkg; hands clamped values to the datapath
module htlm_regs import htlm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [CNT_W-1:0] node_count_q, node_count_d;
  logic [BR_W-1:0]  branch_q, branch_d;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    node_count_d = node_count_q;
    branch_d     = branch_q;
    if (wr_en) begin
      if (paddr[2] == REG_NODE_COUNT) begin
        node_count_d = pwdata[CNT_W-1:0];
      end else begin
        branch_d = pwdata[BR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
      branch_q     <= BRANCH_RST;
    end else begin
      node_count_q <= node_count_d;
      branch_q     <= branch_d;
    end
  end

  assign prdata = (paddr[2] == REG_BRANCH) ? DATA_W'(branch_q) : DATA_W'(node_count_q);

  always_comb begin
    cfg_o.n = (node_count_q > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count_q;
    if (branch_q == '0) begin
      cfg_o.m = BR_W'(1);
    end else if (branch_q > BR_W'(MAX_BRANCH)) begin
      cfg_o.m = BR_W'(MAX_BRANCH);
    end else begin
      cfg_o.m = branch_q;
    end
  end

endmodule

/* hdl/htlm_ctrl.sv */
// request sequencer: range check, ancestor walk, subtree sweep, commit
// depends on htlm_pkg; drives the datapath through cmd_t, reads sts_t
module htlm_ctrl import htlm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_ANC   = 3'd2;
  localparam logic [2:0] S_DESC  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_UNLK  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       ok;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    ok      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts_i.idx_ok) begin
          cmd_o.set_res = 1'b1;
          state_d       = S_DONE;
        end else if (sts_i.op == OP_UNLOCK) begin
          // owner read of the target node is issued in this cycle
          if (sts_i.idx_locked) begin
            state_d = S_UNLK;
          end else begin
            cmd_o.set_res = 1'b1;
            state_d       = S_DONE;
          end
        end else if (sts_i.idx_locked) begin
          cmd_o.set_res = 1'b1;
          state_d       = S_DONE;
        end else begin
          state_d = S_ANC;
        end
      end
      S_ANC: begin
        if (sts_i.cur_root) begin
          if (sts_i.first_out) begin
            state_d = S_DRAIN;
          end else begin
            cmd_o.desc_begin = 1'b1;
            state_d          = S_DESC;
          end
        end else if (sts_i.par_locked) begin
          cmd_o.set_res = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.anc_step = 1'b1;
        end
      end
      S_DESC: begin
        cmd_o.desc_step = 1'b1;
        if (sts_i.level_end && sts_i.next_out) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last owner compare of the sweep lands here
        if (sts_i.op == OP_LOCK) begin
          ok = !sts_i.seen;
        end else begin
          ok = sts_i.seen && sts_i.clean_now;
        end
        cmd_o.commit_lock = ok;
        cmd_o.set_res     = 1'b1;
        cmd_o.res_val     = ok;
        state_d           = S_DONE;
      end
      S_UNLK: begin
        cmd_o.commit_unlock = sts_i.owner_match;
        cmd_o.set_res       = 1'b1;
        cmd_o.res_val       = sts_i.owner_match;
        state_d             = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hdl/htlm_dp.sv */
// datapath: request latch, lock bits, owner ram, walk pointers, result word
// depends on htlm_pkg and htlm_ram; steered by the sequencer's cmd_t
module htlm_dp import htlm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [1:0]        req_type_i,
  input  logic [NODE_W-1:0] node_index_i,
  input  logic [USER_W-1:0] user_id_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic              granted_o
);

  logic [1:0]           op_q;
  logic [NODE_W-1:0]    idx_q, cur_q, lo_q, hi_q, j_q;
  logic [USER_W-1:0]    user_q;
  logic                 seen_q, clean_q, pend_q, res_q;
  logic [MAX_NODES-1:0] mask_q, locked_q;
  logic                 out_valid_q, granted_q;

  logic [NODE_W-1:0] par;
  lvl_t              dn, dl;
  logic [USER_W-1:0] rdata;
  logic [NODE_W-1:0] raddr;
  logic              mismatch;

  assign par      = parent_of(cur_q, cfg_i.m);
  assign dn       = next_level(idx_q, idx_q, cfg_i.m, cfg_i.n);
  assign dl       = next_level(lo_q, hi_q, cfg_i.m, cfg_i.n);
  assign raddr    = cmd_i.desc_step ? j_q : idx_q;
  assign mismatch = pend_q && (rdata != user_q);

  htlm_ram #(
    .WIDTH (USER_W),
    .DEPTH (MAX_NODES)
  ) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit_lock),
    .waddr_i (idx_q),
    .wdata_i (user_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    sts_o.idx_ok      = (CNT_W'(idx_q) < cfg_i.n) && (op_q != OP_NONE);
    sts_o.op          = op_q;
    sts_o.idx_locked  = locked_q[idx_q];
    sts_o.cur_root    = (cur_q == '0);
    sts_o.par_locked  = locked_q[par];
    sts_o.first_out   = dn.out;
    sts_o.level_end   = (j_q == hi_q);
    sts_o.next_out    = dl.out;
    sts_o.seen        = seen_q;
    sts_o.clean_now   = clean_q && !mismatch;
    sts_o.owner_match = (rdata == user_q);
    sts_o.out_free    = !out_valid_q || !out_stall_i;
  end

  // request word and walk registers
  always_ff @(posedge clk_i) begin
    if (mismatch) begin
      clean_q <= 1'b0;
    end
    if (cmd_i.load) begin
      op_q    <= req_type_i;
      idx_q   <= node_index_i;
      user_q  <= user_id_i;
      cur_q   <= node_index_i;
      seen_q  <= 1'b0;
      clean_q <= 1'b1;
      mask_q  <= '0;
    end
    if (cmd_i.anc_step) begin
      cur_q <= par;
    end
    if (cmd_i.desc_begin) begin
      lo_q <= dn.lo;
      hi_q <= dn.hi;
      j_q  <= dn.lo;
    end
    if (cmd_i.desc_step) begin
      if (locked_q[j_q]) begin
        seen_q      <= 1'b1;
        mask_q[j_q] <= 1'b1;
      end
      if (j_q == hi_q) begin
        lo_q <= dl.lo;
        hi_q <= dl.hi;
        j_q  <= dl.lo;
      end else begin
        j_q <= j_q + NODE_W'(1);
      end
    end
    if (cmd_i.set_res) begin
      res_q <= cmd_i.res_val;
    end
    if (cmd_i.emit) begin
      granted_q <= res_q;
    end
  end

  // lock bits, pending owner compare, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      locked_q    <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= cmd_i.desc_step && locked_q[j_q];
      if (cmd_i.commit_lock) begin
        // releases the swept locked descendants and takes the node
        locked_q <= (locked_q & ~mask_q) | (MAX_NODES'(1) << idx_q);
      end else if (cmd_i.commit_unlock) begin
        locked_q[idx_q] <= 1'b0;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign granted_o   = granted_q;

endmodule

/* hdl/hierarchical_tree_lock_manager_core.sv */
// Tree lock manager for a breadth-first complete m-ary tree of up to 64 nodes. One request
// word (operation, node, user) gives one result word (granted). A request is taken only
// when the block is idle; the previous result may still be waiting in the output register.
// Unlock goes from accept through the check state and the owner compare to the result
// state. Lock and upgrade walk the parent chain, one ancestor per step, then sweep the
// subtree one node per step, and end in a drain state for the owner ram's registered read.
// Ancestors and descendants never overlap. A refused range check, or a lock or upgrade of
// a locked target, goes from the check state straight to the result state. Registers:
// node_count at byte address 0, branching_factor at 4. Reset clears all lock bits at
// once; owners need no clearing pass.
// depends on htlm_pkg, htlm_regs, htlm_ctrl, htlm_dp and htlm_ram
module hierarchical_tree_lock_manager_core import htlm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        req_type_i,
  input  logic [NODE_W-1:0] node_index_i,
  input  logic [USER_W-1:0] user_id_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              granted_o
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  htlm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  htlm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  htlm_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_type_i   (req_type_i),
    .node_index_i (node_index_i),
    .user_id_i    (user_id_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .granted_o    (granted_o)
  );

endmodule
